// ===== sv/assert_macros.svh =====
// Assertion macros shared by the odometry angle and rate core.
// Every macro assumes the clock aclk and the active-low reset aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/oqe_pkg.sv =====
// Package for the odometry angle and rate core: widths, angle constants and
// the CORDIC arctangent table. Depends on nothing.
`default_nettype none

package oqe_pkg;

    // Angle output format and internal datapath widths.
    localparam int ANG_FRAC  = 13;
    localparam int ANG_SHIFT = 30 - ANG_FRAC;
    localparam int CW        = 40;   // CORDIC x and y
    localparam int ZW        = 36;   // CORDIC angle accumulator, Q30
    localparam int QW        = 36;   // quaternion product sums, Q28
    localparam int NUM_W     = 52;   // rate dividend: magnitude times 10^6
    localparam int DT_W      = 48;   // timestamp and time step

    localparam logic signed [ZW-1:0] PI_Z      = ZW'(64'sd3373259426);
    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(64'sd1686629713);
    localparam logic signed [ZW-1:0] RND_Z     = ZW'(64'sd1 <<< (ANG_SHIFT - 1));
    localparam logic signed [ZW-1:0] PI_OUT      =
        ZW'((64'sd3373259426 + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT);
    localparam logic signed [ZW-1:0] HALF_PI_OUT =
        ZW'((64'sd1686629713 + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT);

    localparam logic signed [QW-1:0] Q_ONE = QW'(64'sd268435456);
    localparam logic [19:0] US_PER_S = 20'd1000000;

    // Arctangent of 2^-i in Q30.
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/oqe_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Depends on oqe_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module oqe_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [oqe_pkg::NUM_W-1:0]   num,
    input  logic [oqe_pkg::DT_W-1:0]    den,
    output logic                        done,
    output logic [oqe_pkg::NUM_W-1:0]   quo
);
    import oqe_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DT_W-1:0]   rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DT_W:0]     trial;
    logic [DT_W:0]     diff;
    logic              ge;
    logic [DT_W-1:0]   rem_next;

    // Trial subtraction of the divisor from the shifted remainder.
    assign trial    = {rem_reg, quo_reg[NUM_W-1]};
    assign diff     = trial - {1'b0, den};
    assign ge       = trial >= {1'b0, den};
    assign rem_next = ge ? diff[DT_W-1:0] : trial[DT_W-1:0];

    // Iteration control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out of the quotient word as quotient bits shift in.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    `ASSERT_IMP(a_no_restart, start, !busy_reg)
    `ASSERT_NXT(a_done_pulse, done_reg, !done_reg)
    `ASSERT_NXT(a_start_busy, start, busy_reg)

endmodule

`default_nettype wire

// ===== sv/odom_quaternion_euler_rate_core.sv =====
// Odometry core: an accepted word passes through nine quaternion products, one square, the
// square-root steps and CORDIC_STEPS micro-rotations for each of the three angles; when rates
// are formed, four rates each take a multiply, a serial divide and a saturate step, then the load.
// One word is in flight at a time: a new word is accepted only once the last is loaded, later if
// the output register still holds a word waiting for m_ready. Reset (aresetn low,
// synchronous) clears the sequencer, valid flags and the stored previous sample.
`default_nettype none
`include "assert_macros.svh"

module odom_quaternion_euler_rate_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic [47:0]        s_timestamp_us,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic signed [15:0] m_roll,
    output logic signed [14:0] m_pitch,
    output logic signed [15:0] m_yaw,
    output logic signed [31:0] m_vel_x,
    output logic signed [31:0] m_vel_y,
    output logic signed [31:0] m_vel_z,
    output logic signed [31:0] m_yaw_rate,
    output logic               m_rate_valid
);
    import oqe_pkg::*;

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    localparam logic [1:0] ANG_ROLL  = 2'd0;
    localparam logic [1:0] ANG_PITCH = 2'd1;
    localparam logic [1:0] ANG_YAW   = 2'd2;
    localparam logic [1:0] RATE_YAW  = 2'd3;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_PROD = 12'b0000_0000_0010,
        ST_SQR  = 12'b0000_0000_0100,
        ST_ISQ  = 12'b0000_0000_1000,
        ST_CSET = 12'b0000_0001_0000,
        ST_CORD = 12'b0000_0010_0000,
        ST_CEND = 12'b0000_0100_0000,
        ST_RSET = 12'b0000_1000_0000,
        ST_RMUL = 12'b0001_0000_0000,
        ST_DIV  = 12'b0010_0000_0000,
        ST_RSAT = 12'b0100_0000_0000,
        ST_DONE = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Latched input word.
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic [DT_W-1:0]    t_reg, dt_reg;
    logic               rv_reg;

    // Previous sample.
    logic               have_prev_reg;
    logic [DT_W-1:0]    prev_t_reg;
    logic signed [31:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic signed [15:0] prev_yaw_reg;

    // Quaternion products and shared multiplier.
    logic signed [31:0] prod_reg [0:8];
    logic [3:0]         k_reg;
    logic signed [15:0] opa, opb;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;

    // Square root iteration.
    logic [56:0] iv_reg, ir_reg, ib_reg, irb;

    // CORDIC.
    logic signed [CW-1:0] cx_reg, cy_reg, sel_x, sel_y, xs, ys;
    logic signed [ZW-1:0] cz_reg, atan_z, z_eff, z_rnd, z_lim, z_cl;
    logic                 zero_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [1:0]           ang_reg;
    logic signed [15:0]   roll_reg, yaw_reg;
    logic signed [14:0]   pitch_reg;

    // Rates.
    logic [1:0]           j_reg;
    logic [32:0]          mag_reg, mag_c;
    logic                 neg_reg, neg_c;
    logic [NUM_W-1:0]     num_reg, div_quo, r_sh;
    logic                 div_go_reg, div_done;
    logic signed [31:0]   vel_reg [0:3];
    logic signed [31:0]   sat_c;
    logic signed [32:0]   pdiff, pcur, pprev;
    logic signed [17:0]   yd0, yd;
    logic [16:0]          ydmag;

    // Angle terms in Q28.
    logic signed [QW-1:0] e [0:8];
    logic signed [QW-1:0] sr_c, cr_c, sp_raw, sy_c, cy_c;
    logic signed [29:0]   sp_c;

    // Output register.
    logic               m_valid_reg;
    logic               load_out;
    logic signed [31:0] o_x_reg, o_y_reg, o_z_reg;
    logic signed [15:0] o_roll_reg, o_yaw_reg;
    logic signed [14:0] o_pitch_reg;
    logic signed [31:0] o_vel_reg [0:3];
    logic               o_rv_reg;
    logic               rates_zero;

    assign s_ready  = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Sum terms of the three angles.
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            e[i] = QW'(prod_reg[i]);
        end
        sr_c   = (e[0] + e[1]) <<< 1;
        cr_c   = Q_ONE - ((e[2] + e[3]) <<< 1);
        sp_raw = (e[4] - e[5]) <<< 1;
        sy_c   = (e[6] + e[7]) <<< 1;
        cy_c   = Q_ONE - ((e[3] + e[8]) <<< 1);
        if (sp_raw > Q_ONE) begin
            sp_c = Q_ONE[29:0];
        end else if (sp_raw < -Q_ONE) begin
            sp_c = 30'(-Q_ONE);
        end else begin
            sp_c = sp_raw[29:0];
        end
    end

    // Operand pair for each quaternion product.
    always_comb begin
        case (k_reg)
            4'd0:    begin opa = qw_reg; opb = qx_reg; end
            4'd1:    begin opa = qy_reg; opb = qz_reg; end
            4'd2:    begin opa = qx_reg; opb = qx_reg; end
            4'd3:    begin opa = qy_reg; opb = qy_reg; end
            4'd4:    begin opa = qw_reg; opb = qy_reg; end
            4'd5:    begin opa = qz_reg; opb = qx_reg; end
            4'd6:    begin opa = qw_reg; opb = qz_reg; end
            4'd7:    begin opa = qx_reg; opb = qy_reg; end
            4'd8:    begin opa = qz_reg; opb = qz_reg; end
            default: begin opa = '0; opb = '0; end
        endcase
    end

    // Shared multiplier: quaternion products, pitch square, rate scaling.
    always_comb begin
        case (state_reg)
            ST_PROD: begin
                mul_a = 34'(opa);
                mul_b = 34'(opb);
            end
            ST_SQR: begin
                mul_a = 34'(sp_c);
                mul_b = 34'(sp_c);
            end
            ST_RMUL: begin
                mul_a = $signed({1'b0, mag_reg});
                mul_b = $signed(34'(US_PER_S));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // CORDIC operand selection and micro-rotation terms.
    always_comb begin
        case (ang_reg)
            ANG_ROLL:  begin sel_y = CW'(sr_c); sel_x = CW'(cr_c); end
            ANG_PITCH: begin sel_y = CW'(sp_c); sel_x = $signed(CW'(ir_reg[28:0])); end
            ANG_YAW:   begin sel_y = CW'(sy_c); sel_x = CW'(cy_c); end
            default:   begin sel_y = '0; sel_x = '0; end
        endcase
        xs     = cx_reg >>> step_reg;
        ys     = cy_reg >>> step_reg;
        atan_z = $signed(ZW'(atan_q30(5'(step_reg))));
    end

    // Round the angle to the output format and clamp it.
    always_comb begin
        z_eff = zero_reg ? '0 : cz_reg;
        z_rnd = (z_eff + RND_Z) >>> ANG_SHIFT;
        z_lim = (ang_reg == ANG_PITCH) ? HALF_PI_OUT : PI_OUT;
        if (z_rnd > z_lim) begin
            z_cl = z_lim;
        end else if (z_rnd < -z_lim) begin
            z_cl = -z_lim;
        end else begin
            z_cl = z_rnd;
        end
    end

    // Difference magnitude for the rate in progress; yaw wraps to +/- pi.
    always_comb begin
        case (j_reg)
            2'd0:    begin pcur = 33'(px_reg); pprev = 33'(prev_x_reg); end
            2'd1:    begin pcur = 33'(py_reg); pprev = 33'(prev_y_reg); end
            default: begin pcur = 33'(pz_reg); pprev = 33'(prev_z_reg); end
        endcase
        pdiff = pcur - pprev;
        yd0   = 18'(yaw_reg) - 18'(prev_yaw_reg);
        if (yd0 > 18'(PI_OUT)) begin
            yd = yd0 - 18'(PI_OUT <<< 1);
        end else if (yd0 < -18'(PI_OUT)) begin
            yd = yd0 + 18'(PI_OUT <<< 1);
        end else begin
            yd = yd0;
        end
        ydmag = yd[17] ? 17'(-yd) : yd[16:0];
        if (j_reg == RATE_YAW) begin
            neg_c = yd[17];
            mag_c = 33'(ydmag) << 16;
        end else begin
            neg_c = pdiff[32];
            mag_c = pdiff[32] ? 33'(-pdiff) : 33'(pdiff);
        end
    end

    // Scale and saturate the quotient to the signed 32-bit range.
    always_comb begin
        r_sh = (j_reg == RATE_YAW) ? (div_quo >> ANG_FRAC) : div_quo;
        if (!neg_reg) begin
            sat_c = (r_sh > NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(r_sh[31:0]);
        end else begin
            sat_c = (r_sh >= NUM_W'(33'h1_0000_0000 >> 1)) ? 32'sh8000_0000
                                                          : $signed(32'd0 - r_sh[31:0]);
        end
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_PROD;
            ST_PROD: if (k_reg == 4'd8) state_next = ST_SQR;
            ST_SQR:  state_next = ST_ISQ;
            ST_ISQ:  if (ib_reg[0]) state_next = ST_CSET;
            ST_CSET: state_next = ST_CORD;
            ST_CORD: if (step_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = ST_CEND;
            ST_CEND: begin
                if (ang_reg != ANG_YAW) begin
                    state_next = ST_CSET;
                end else if (rv_reg) begin
                    state_next = ST_RSET;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_RSET: state_next = ST_RMUL;
            ST_RMUL: state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_RSAT;
            ST_RSAT: state_next = (j_reg == RATE_YAW) ? ST_DONE : ST_RSET;
            ST_DONE: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_t_reg    <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            prev_yaw_reg  <= '0;
            div_go_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            div_go_reg <= (state_reg == ST_RMUL);
            if (load_out) begin
                m_valid_reg   <= 1'b1;
                have_prev_reg <= 1'b1;
                prev_t_reg    <= t_reg;
                prev_x_reg    <= px_reg;
                prev_y_reg    <= py_reg;
                prev_z_reg    <= pz_reg;
                prev_yaw_reg  <= yaw_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    px_reg <= s_pos_x;
                    py_reg <= s_pos_y;
                    pz_reg <= s_pos_z;
                    qw_reg <= s_quat_w;
                    qx_reg <= s_quat_x;
                    qy_reg <= s_quat_y;
                    qz_reg <= s_quat_z;
                    t_reg  <= s_timestamp_us;
                    dt_reg <= s_timestamp_us - prev_t_reg;
                    rv_reg <= have_prev_reg && (s_timestamp_us > prev_t_reg);
                    k_reg  <= '0;
                end
            end
            ST_PROD: begin
                prod_reg[k_reg] <= mul_p[31:0];
                k_reg           <= k_reg + 4'd1;
            end
            ST_SQR: begin
                iv_reg  <= (57'd1 << 56) - mul_p[56:0];
                ir_reg  <= '0;
                ib_reg  <= 57'd1 << 56;
                ang_reg <= ANG_ROLL;
            end
            ST_ISQ: begin
                if (iv_reg >= irb) begin
                    iv_reg <= iv_reg - irb;
                    ir_reg <= (ir_reg >> 1) + ib_reg;
                end else begin
                    ir_reg <= ir_reg >> 1;
                end
                ib_reg <= ib_reg >> 2;
            end
            ST_CSET: begin
                zero_reg <= (sel_x == '0) && (sel_y == '0);
                step_reg <= '0;
                if (sel_x < 0) begin
                    cz_reg <= (sel_y >= 0) ? PI_Z : -PI_Z;
                    cx_reg <= -sel_x;
                    cy_reg <= -sel_y;
                end else begin
                    cz_reg <= '0;
                    cx_reg <= sel_x;
                    cy_reg <= sel_y;
                end
            end
            ST_CORD: begin
                step_reg <= step_reg + 1'b1;
                if (cy_reg >= 0) begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atan_z;
                end else begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atan_z;
                end
            end
            ST_CEND: begin
                case (ang_reg)
                    ANG_ROLL:  roll_reg  <= z_cl[15:0];
                    ANG_PITCH: pitch_reg <= z_cl[14:0];
                    default:   yaw_reg   <= z_cl[15:0];
                endcase
                ang_reg <= ang_reg + 2'd1;
                j_reg   <= '0;
            end
            ST_RSET: begin
                mag_reg <= mag_c;
                neg_reg <= neg_c;
            end
            ST_RMUL: begin
                num_reg <= mul_p[NUM_W-1:0];
            end
            ST_RSAT: begin
                vel_reg[j_reg] <= sat_c;
                j_reg          <= j_reg + 2'd1;
            end
            default: begin
            end
        endcase
    end

    assign irb = ir_reg + ib_reg;

    // Output register; rates read zero when there is no valid time step.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            o_x_reg     <= px_reg;
            o_y_reg     <= py_reg;
            o_z_reg     <= pz_reg;
            o_roll_reg  <= roll_reg;
            o_pitch_reg <= pitch_reg;
            o_yaw_reg   <= yaw_reg;
            o_rv_reg    <= rv_reg;
            for (int i = 0; i < 4; i++) begin
                o_vel_reg[i] <= rv_reg ? vel_reg[i] : '0;
            end
        end
    end

    oqe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go_reg),
        .num     (num_reg),
        .den     (dt_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign m_valid      = m_valid_reg;
    assign m_out_x      = o_x_reg;
    assign m_out_y      = o_y_reg;
    assign m_out_z      = o_z_reg;
    assign m_roll       = o_roll_reg;
    assign m_pitch      = o_pitch_reg;
    assign m_yaw        = o_yaw_reg;
    assign m_vel_x      = o_vel_reg[0];
    assign m_vel_y      = o_vel_reg[1];
    assign m_vel_z      = o_vel_reg[2];
    assign m_yaw_rate   = o_vel_reg[3];
    assign m_rate_valid = o_rv_reg;

    // All four rate fields are zero.
    assign rates_zero = (m_vel_x == '0) && (m_vel_y == '0) && (m_vel_z == '0)
                        && (m_yaw_rate == '0);

    `ASSERT_IMP(a_norate_zero, m_valid && !m_rate_valid, rates_zero)
    `ASSERT_IMP(a_div_in_div, div_done, state_reg == ST_DIV)
    `ASSERT_IMP(a_pitch_range, m_valid, m_pitch <= 15'sd12868 && m_pitch >= -15'sd12868)
    `ASSERT_NXT(a_accept_busy, s_valid && s_ready, !s_ready)

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for odom_quaternion_euler_rate_core: directed odometry samples, then random ones,
// checked field by field against known results or a model of the angle and rate math.
// Depends only on the core RTL.
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic [47:0]        ts;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] yr;
        logic               rv;
    } pose_t;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint Q28_ONE     = 64'sd268435456;
    localparam int     NUM_ITEMS   = 600;
    localparam int     IDLE_LIMIT  = 20000;
    localparam int     DRAIN_WAIT  = 1000;
    localparam int     HOLD_CYCLES = 3000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_pos_x = '0;
    logic signed [31:0] s_pos_y = '0;
    logic signed [31:0] s_pos_z = '0;
    logic signed [15:0] s_quat_w = '0;
    logic signed [15:0] s_quat_x = '0;
    logic signed [15:0] s_quat_y = '0;
    logic signed [15:0] s_quat_z = '0;
    logic [47:0]        s_timestamp_us = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_out_x, m_out_y, m_out_z;
    logic signed [15:0] m_roll, m_yaw;
    logic signed [14:0] m_pitch;
    logic signed [31:0] m_vel_x, m_vel_y, m_vel_z, m_yaw_rate;
    logic               m_rate_valid;

    odom_quaternion_euler_rate_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_quat_w(s_quat_w), .s_quat_x(s_quat_x), .s_quat_y(s_quat_y), .s_quat_z(s_quat_z),
        .s_timestamp_us(s_timestamp_us),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_x(m_out_x), .m_out_y(m_out_y), .m_out_z(m_out_z),
        .m_roll(m_roll), .m_pitch(m_pitch), .m_yaw(m_yaw),
        .m_vel_x(m_vel_x), .m_vel_y(m_vel_y), .m_vel_z(m_vel_z),
        .m_yaw_rate(m_yaw_rate), .m_rate_valid(m_rate_valid)
    );

    // Clock: 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Model state: the previous sample.
    bit              prev_valid;
    longint unsigned prev_time;
    longint          prev_x, prev_y, prev_z, prev_yaw;
    longint          atan_tab [16] = '{
        843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767
    };

    pose_t pose_q[$];
    int    errors = 0;
    int    words_in = 0;
    int    words_out = 0;
    int    rate_words = 0;
    int    idle_cycles = 0;
    bit    sending_done = 1'b0;

    // CORDIC vectoring in Q30 with floor shifts and a half-turn pre-rotation.
    function automatic longint cordic_angle(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_Q30 : -PI_Q30;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + atan_tab[i];
            end else begin
                x = x - ys; y = y + xs; z = z - atan_tab[i];
            end
        end
        return z;
    endfunction

    function automatic longint round_q13(longint z);
        return (z + (64'sd1 <<< 16)) >>> 17;
    endfunction

    function automatic longint clamp_angle(longint z, longint lim_q30);
        longint lim, a;
        lim = round_q13(lim_q30);
        a = round_q13(z);
        if (a > lim) a = lim;
        if (a < -lim) a = -lim;
        return a;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Per-second rate of a difference over dt microseconds, saturated to 32 bits.
    function automatic longint diff_rate(longint num, longint unsigned dt, int shift);
        longint unsigned mag, q, r, t, a, b, res;
        mag = (num < 0) ? -num : num;
        q = mag / dt;
        r = mag % dt;
        if (q >= (64'd1 << 40)) begin
            res = 64'd1 << 60;
        end else begin
            t = r * 1000;
            a = t / dt;
            b = t % dt;
            res = q * 1000000 + a * 1000 + (b * 1000) / dt;
        end
        res = res >> shift;
        if (num >= 0) return (res > 64'd2147483647) ? 64'sd2147483647 : longint'(res);
        if (res >= (64'd1 << 31)) return -64'sd2147483648;
        return -longint'(res);
    endfunction

    // Expected pose and rates for one accepted sample; updates the previous sample.
    function automatic pose_t predict_pose(sample_t s);
        pose_t           p;
        longint          w, x, y, z, sr, cr, sp, cp, sy, cy, d, pi_out;
        longint          roll, pitch, yaw, px, py, pz;
        longint unsigned ts, dt;
        w = s.qw; x = s.qx; y = s.qy; z = s.qz;
        px = s.pos_x; py = s.pos_y; pz = s.pos_z;
        ts = s.ts;
        sr = 2 * (w * x + y * z);
        cr = Q28_ONE - 2 * (x * x + y * y);
        roll = clamp_angle(cordic_angle(sr, cr), PI_Q30);
        sp = 2 * (w * y - z * x);
        if (sp > Q28_ONE) sp = Q28_ONE;
        if (sp < -Q28_ONE) sp = -Q28_ONE;
        cp = longint'(int_sqrt((64'd1 << 56) - longint'(sp * sp)));
        pitch = clamp_angle(cordic_angle(sp, cp), HALF_PI_Q30);
        sy = 2 * (w * z + x * y);
        cy = Q28_ONE - 2 * (y * y + z * z);
        yaw = clamp_angle(cordic_angle(sy, cy), PI_Q30);
        p = '0;
        p.ox = s.pos_x; p.oy = s.pos_y; p.oz = s.pos_z;
        p.roll = 16'(roll); p.pitch = 15'(pitch); p.yaw = 16'(yaw);
        if (prev_valid && ts > prev_time) begin
            dt = ts - prev_time;
            pi_out = round_q13(PI_Q30);
            d = yaw - prev_yaw;
            if (d > pi_out) d = d - 2 * pi_out;
            if (d < -pi_out) d = d + 2 * pi_out;
            p.rv = 1'b1;
            p.vx = 32'(diff_rate(px - prev_x, dt, 0));
            p.vy = 32'(diff_rate(py - prev_y, dt, 0));
            p.vz = 32'(diff_rate(pz - prev_z, dt, 0));
            p.yr = 32'(diff_rate(d * 65536, dt, 13));
        end
        prev_valid = 1'b1;
        prev_time = ts;
        prev_x = px; prev_y = py; prev_z = pz;
        prev_yaw = yaw;
        return p;
    endfunction

    function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
        end
    endfunction

    // Result monitor: every accepted word is compared with the oldest expectation.
    always @(posedge aclk) begin
        pose_t e;
        if (aresetn && m_valid && m_ready) begin
            words_out++;
            if (pose_q.size() == 0) begin
                errors++;
                $display("%0t: result word with no expectation waiting", $time);
            end else begin
                e = pose_q.pop_front();
                if (e.rv) rate_words++;
                check_field("out_x", e.ox, m_out_x);
                check_field("out_y", e.oy, m_out_y);
                check_field("out_z", e.oz, m_out_z);
                check_field("roll", e.roll, m_roll);
                check_field("pitch", e.pitch, m_pitch);
                check_field("yaw", e.yaw, m_yaw);
                check_field("vel_x", e.vx, m_vel_x);
                check_field("vel_y", e.vy, m_vel_y);
                check_field("vel_z", e.vz, m_vel_z);
                check_field("yaw_rate", e.yr, m_yaw_rate);
                check_field("rate_valid", e.rv, m_rate_valid);
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stalls in phases, one long hold-off, and stall-free stretches.
    initial begin
        int  mode;
        int  phase_left;
        bit  held;
        mode = 0;
        phase_left = 0;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && words_in >= 60) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end
            if (phase_left == 0) begin
                mode = $urandom_range(0, 2);
                phase_left = $urandom_range(50, 2000);
            end
            phase_left--;
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Sender side.
    sample_t dir_rows[$];
    pose_t   dir_exp[$];
    bit      dir_has_exp[$];
    int      burst_left = 0;
    sample_t last_sent = '0;

    function automatic void add_row(logic signed [31:0] x, logic signed [31:0] y,
                                    logic signed [31:0] z, logic signed [15:0] qw,
                                    logic signed [15:0] qx, logic signed [15:0] qy,
                                    logic signed [15:0] qz, logic [47:0] ts);
        sample_t s;
        s = '{x, y, z, qw, qx, qy, qz, ts};
        dir_rows.push_back(s);
        dir_has_exp.push_back(1'b0);
        dir_exp.push_back('0);
    endfunction

    // Row with a result that is known without computing it.
    function automatic void add_known(sample_t s, pose_t p);
        dir_rows.push_back(s);
        dir_has_exp.push_back(1'b1);
        dir_exp.push_back(p);
    endfunction

    task automatic send_word(sample_t s, bit has_exp, pose_t known);
        pose_t p;
        int    gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_pos_x        <= s.pos_x;
        s_pos_y        <= s.pos_y;
        s_pos_z        <= s.pos_z;
        s_quat_w       <= s.qw;
        s_quat_x       <= s.qx;
        s_quat_y       <= s.qy;
        s_quat_z       <= s.qz;
        s_timestamp_us <= s.ts;
        do @(posedge aclk); while (!s_ready);
        p = predict_pose(s);
        pose_q.push_back(has_exp ? known : p);
        words_in++;
        last_sent = s;
        @(negedge aclk);
    endtask

    function automatic logic signed [15:0] rand_q();
        return 16'($urandom_range(0, 32768)) - 16'sd16384;
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        int      sel;
        sel = $urandom_range(0, 99);
        s.qw = rand_q(); s.qx = rand_q(); s.qy = rand_q(); s.qz = rand_q();
        if ($urandom_range(0, 4) == 0) begin
            s.pos_x = $urandom; s.pos_y = $urandom; s.pos_z = $urandom;
        end else begin
            s.pos_x = last_sent.pos_x + 32'($signed($urandom_range(0, 2000000)) - 1000000);
            s.pos_y = last_sent.pos_y + 32'($signed($urandom_range(0, 2000000)) - 1000000);
            s.pos_z = last_sent.pos_z + 32'($signed($urandom_range(0, 2000000)) - 1000000);
        end
        if (sel < 78) s.ts = last_sent.ts + 48'($urandom_range(1, 200000));
        else if (sel < 84) s.ts = last_sent.ts + 48'($urandom_range(1, 4));
        else if (sel < 89) s.ts = last_sent.ts;
        else if (sel < 93) s.ts = last_sent.ts - 48'($urandom_range(1, 100000));
        else s.ts = {16'($urandom), 32'($urandom)};
        return s;
    endfunction

    initial begin
        pose_t   k;
        sample_t s;
        prev_valid = 1'b0;
        prev_time = 0;
        prev_x = 0; prev_y = 0; prev_z = 0; prev_yaw = 0;

        // First sample after reset: identity attitude, no rates yet.
        s = '{32'sd65536, -32'sd65536, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 48'd1000};
        k = '{32'sd65536, -32'sd65536, 32'sd0, 16'sd0, 15'sd0, 16'sd0, 32'sd0, 32'sd0,
              32'sd0, 32'sd0, 1'b0};
        add_known(s, k);
        // Half turn in roll with a repeated timestamp: roll is +pi, no rates.
        s = '{32'sd1, 32'sd2, 32'sd3, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 48'd1000};
        k = '{32'sd1, 32'sd2, 32'sd3, 16'sd25736, 15'sd0, 16'sd0, 32'sd0, 32'sd0,
              32'sd0, 32'sd0, 1'b0};
        add_known(s, k);
        // Position extremes one microsecond apart, so the velocities saturate.
        add_row(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'sd16384, 0, 0, 0, 48'd1001);
        add_row(32'h80000000, 32'h7fffffff, 32'h80000000, -16'sd16384, 0, 0, 0, 48'd1002);
        // Yaw at +pi, then just past -pi: the yaw difference wraps.
        add_row(0, 0, 0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 48'd2002);
        add_row(0, 0, 0, -16'sd300, 16'sd0, 16'sd0, 16'sd16384, 48'd3002);
        add_row(0, 0, 0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 48'd4002);
        // Arcsine term beyond +1 and below -1 is clamped; pitch at +-pi/2.
        add_row(5, 5, 5, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 48'd5002);
        add_row(6, 6, 6, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 48'd6002);
        // Not normalized quaternions, and all components zero.
        add_row(7, 7, 7, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 48'd7002);
        add_row(8, 8, 8, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 48'd8002);
        add_row(9, 9, 9, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 48'd9002);
        // Negative x in atan2 with y below zero.
        add_row(0, 0, 0, -16'sd1000, 16'sd16000, 16'sd0, 16'sd0, 48'd10002);
        // Timestamp going back, then the largest timestamp and a huge step.
        add_row(100, 100, 100, 16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 48'd500);
        add_row(-100, -100, -100, 16'sd11585, 16'sd0, 16'sd0, -16'sd11585,
                48'hffffffffffff);
        add_row(0, 0, 0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 48'd0);
        add_row(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f, 16'sd8192, 16'sd8192,
                16'sd8192, 16'sd8192, 48'h800000000000);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < dir_rows.size(); i++)
            send_word(dir_rows[i], dir_has_exp[i], dir_exp[i]);

        // Random part: mostly steady motion with some repeated, reversed and jumping time.
        for (int i = 0; i < NUM_ITEMS; i++) send_word(random_sample(), 1'b0, '0);
        s_valid <= 1'b0;
        sending_done = 1'b1;

        while (pose_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Sent %0d odometry words, checked %0d results, %0d with valid rates.",
                 words_in, words_out, rate_words);
        if (errors == 0 && pose_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== odom_quaternion_euler_rate_core.f =====
+incdir+sv
sv/oqe_pkg.sv
sv/oqe_div.sv
sv/odom_quaternion_euler_rate_core.sv
test/tb_top.sv
